// ===== hdl/scc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes and types of the strong connectivity checker: row width,
// vertex and count widths, the merge unit's operation codes and request types.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned ROW_AW       = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VTX_W        = 6;

  localparam logic OP_ARC  = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic {
    UOP_CLOSE  = 1'b0,
    UOP_SETBIT = 1'b1
  } uop_e;

  // Merge unit request: operation and the column it works on
  // (pivot for closure, target bit for an arc insert)
  typedef struct packed {
    uop_e              uop;
    logic [ROW_AW-1:0] sel;
  } unit_ctl_t;

  // Row memory request
  typedef struct packed {
    logic              clr;
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic              re;
    logic [ROW_AW-1:0] raddr;
  } ram_req_t;

endpackage : scc_pkg
`default_nettype wire

// ===== hdl/scc_row_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_row_ram
// Reachability row store: one write and one registered read per cycle, with a
// valid bit per row so that one clear request empties the whole store.
// ----------------------------------------------------------------------------
module scc_row_ram (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scc_pkg::ram_req_t req_i,
  input  scc_pkg::row_t    wdata_i,
  output scc_pkg::row_t    rdata_o
);
  import scc_pkg::*;

  row_t                    mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  row_t                    rdata_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.re) begin
        rd_vld_q <= row_vld_q[req_i.raddr];
      end
      if (req_i.clr) begin
        row_vld_q <= '0;
      end else if (req_i.we) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  // A row never written since the last clear reads as empty
  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule : scc_row_ram
`default_nettype wire

// ===== hdl/scc_row_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_row_unit
// Shared row unit: merges the pivot row into a row that reaches the pivot,
// sets a single bit for an arc insert, and flags a row full over columns 0..N-1.
// ----------------------------------------------------------------------------
module scc_row_unit (
  input  scc_pkg::unit_ctl_t        ctl_i,
  input  scc_pkg::row_t             row_i,
  input  scc_pkg::row_t             pivot_i,
  input  logic [scc_pkg::CNT_W-1:0] n_i,
  output scc_pkg::row_t             row_o,
  output logic                      full_o
);
  import scc_pkg::*;

  row_t col_mask;
  row_t sel_bit;

  always_comb begin
    col_mask = '0;
    for (int c = 0; c < MAX_VERTICES; c++) begin
      col_mask[c] = (CNT_W'(c) < n_i);
    end
  end

  assign sel_bit = row_t'(1) << ctl_i.sel;

  always_comb begin
    unique case (ctl_i.uop)
      UOP_CLOSE:  row_o = row_i[ctl_i.sel] ? (row_i | pivot_i) : row_i;
      UOP_SETBIT: row_o = row_i | sel_bit;
      default:    row_o = row_i;
    endcase
  end

  assign full_o = &(row_i | ~col_mask);

endmodule : scc_row_unit
`default_nettype wire

// ===== hdl/strong_connectivity_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strong_connectivity_check
// Directed-graph strong connectivity check by Warshall closure on a bit
// matrix of reachability rows, one shared row unit over a single row store.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Word
//  -------  ------------------------  -----------------------------------------
//  in       in_valid_i / in_stall_o   op_i, from_vertex_i, to_vertex_i, two_way_i
//  out      out_valid_o / out_stall_i strongly_connected_o
//  cfg      cfg_we_i                  cfg_wdata_i (num_vertices)
//
//  An in-range arc word keeps the input stalled through ST_ARC_A (and ST_ARC_B
//  when two-way) while its rows are read back and written. An evaluate word
//  runs the closure pivot by pivot: read the pivot row (ST_PRD), latch it
//  (ST_PLAT), merge the rows (ST_ROWS), write back the last (ST_RDRN); then
//  check the rows (ST_CHK, ST_CDRN) and hand over the verdict (ST_FIN). One
//  row passes the unit per cycle while rows stream. The store clears at once
//  through per-row valid bits; there is no clearing pass after reset. A
//  verdict still stalled at the output holds the block in ST_FIN until taken.
// ----------------------------------------------------------------------------
module strong_connectivity_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [scc_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [scc_pkg::VTX_W-1:0] from_vertex_i,
  input  logic [scc_pkg::VTX_W-1:0] to_vertex_i,
  input  logic                      two_way_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      strongly_connected_o
);
  import scc_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ARC_A = 4'd1;  // first arc row back: write it
  localparam logic [3:0] ST_ARC_B = 4'd2;  // reverse arc row back: write it
  localparam logic [3:0] ST_PRD   = 4'd3;  // read the pivot row
  localparam logic [3:0] ST_PLAT  = 4'd4;  // latch the pivot row
  localparam logic [3:0] ST_ROWS  = 4'd5;  // stream rows through the merge
  localparam logic [3:0] ST_RDRN  = 4'd6;  // write back the last row
  localparam logic [3:0] ST_CHK   = 4'd7;  // stream rows through the check
  localparam logic [3:0] ST_CDRN  = 4'd8;  // check the last row
  localparam logic [3:0] ST_FIN   = 4'd9;  // hand over verdict, clear store

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cfg_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  n_eff;
  logic [ROW_AW-1:0] k_q, k_d;
  logic [ROW_AW-1:0] i_q, i_d;
  logic [ROW_AW-1:0] prev_q, prev_d;
  logic              pend_q, pend_d;
  logic [ROW_AW-1:0] v_q, v_d;
  logic [ROW_AW-1:0] w_q, w_d;
  logic              two_q, two_d;
  row_t              pivot_q, pivot_d;
  logic              ok_q, ok_d;
  logic              out_vld_q, out_vld_d;
  logic              res_q, res_d;

  logic              in_acc;
  logic              arc_ok;
  logic              i_last;
  logic              k_last;
  ram_req_t          ram_req;
  unit_ctl_t         unit_ctl;
  row_t              rdata;
  row_t              unit_row;
  logic              unit_full;

  // Count in force: zero means one vertex, clamp above the row width
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_q > CNT_W'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = cfg_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Both ends must name a vertex in 1..N
  assign arc_ok = (from_vertex_i != '0) && (to_vertex_i != '0) &&
                  ({1'b0, from_vertex_i} <= n_eff) && ({1'b0, to_vertex_i} <= n_eff);

  assign i_last = ({1'b0, i_q} == (n_q - CNT_W'(1)));
  assign k_last = ({1'b0, k_q} == (n_q - CNT_W'(1)));

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    k_d       = k_q;
    i_d       = i_q;
    prev_d    = prev_q;
    pend_d    = 1'b0;
    v_d       = v_q;
    w_d       = w_q;
    two_d     = two_q;
    pivot_d   = pivot_q;
    ok_d      = ok_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && out_stall_i;
    ram_req   = '0;
    unit_ctl  = '{uop: UOP_CLOSE, sel: k_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_EVAL) begin
            n_d     = n_eff;
            k_d     = '0;
            state_d = ST_PRD;
          end else if (arc_ok) begin
            v_d           = ROW_AW'(from_vertex_i - VTX_W'(1));
            w_d           = ROW_AW'(to_vertex_i - VTX_W'(1));
            two_d         = two_way_i;
            ram_req.re    = 1'b1;
            ram_req.raddr = ROW_AW'(from_vertex_i - VTX_W'(1));
            state_d       = ST_ARC_A;
          end
        end
      end
      ST_ARC_A: begin
        unit_ctl      = '{uop: UOP_SETBIT, sel: w_q};
        ram_req.we    = 1'b1;
        ram_req.waddr = v_q;
        if (two_q) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = w_q;
          state_d       = ST_ARC_B;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ARC_B: begin
        unit_ctl      = '{uop: UOP_SETBIT, sel: v_q};
        ram_req.we    = 1'b1;
        ram_req.waddr = w_q;
        state_d       = ST_IDLE;
      end
      ST_PRD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = k_q;
        state_d       = ST_PLAT;
      end
      ST_PLAT: begin
        pivot_d = rdata;
        i_d     = '0;
        state_d = ST_ROWS;
      end
      ST_ROWS: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = i_q;
        prev_d        = i_q;
        pend_d        = 1'b1;
        ram_req.we    = pend_q;
        ram_req.waddr = prev_q;
        if (i_last) begin
          state_d = ST_RDRN;
        end else begin
          i_d = i_q + ROW_AW'(1);
        end
      end
      ST_RDRN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = prev_q;
        if (k_last) begin
          i_d     = '0;
          ok_d    = 1'b1;
          state_d = ST_CHK;
        end else begin
          k_d     = k_q + ROW_AW'(1);
          state_d = ST_PRD;
        end
      end
      ST_CHK: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = i_q;
        pend_d        = 1'b1;
        if (pend_q) begin
          ok_d = ok_q && unit_full;
        end
        if (i_last) begin
          state_d = ST_CDRN;
        end else begin
          i_d = i_q + ROW_AW'(1);
        end
      end
      ST_CDRN: begin
        ok_d    = ok_q && unit_full;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_vld_q || !out_stall_i) begin
          res_d       = ok_q;
          out_vld_d   = 1'b1;
          ram_req.clr = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CNT_W'(1);
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    k_q     <= k_d;
    i_q     <= i_d;
    prev_q  <= prev_d;
    v_q     <= v_d;
    w_q     <= w_d;
    two_q   <= two_d;
    pivot_q <= pivot_d;
    ok_q    <= ok_d;
    res_q   <= res_d;
  end

  scc_row_ram u_row_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .wdata_i (unit_row),
    .rdata_o (rdata)
  );

  scc_row_unit u_row_unit (
    .ctl_i   (unit_ctl),
    .row_i   (rdata),
    .pivot_i (pivot_q),
    .n_i     (n_q),
    .row_o   (unit_row),
    .full_o  (unit_full)
  );

  assign out_valid_o          = out_vld_q;
  assign strongly_connected_o = res_q;

endmodule : strong_connectivity_check
`default_nettype wire

// ===== hdl/scc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks of the strong connectivity checker, bound to its top.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic op_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic strongly_connected_o
);
  import scc_pkg::*;

  // A stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(strongly_connected_o))
    else $error("verdict dropped or changed while stalled");

  // An evaluate word keeps the input stalled on the next cycle
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_EVAL) |=> in_stall_o)
    else $error("input taken straight after an evaluate word");

  // An arc word never raises a verdict
  a_arc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_ARC) && !out_valid_o |=> !out_valid_o)
    else $error("verdict raised by an arc word");

  // A verdict only appears at the end of a busy spell
  a_verdict_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("verdict without an evaluation");

endmodule : scc_checker

bind strong_connectivity_check scc_checker u_scc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .op_i                 (op_i),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .strongly_connected_o (strongly_connected_o)
);
`default_nettype wire
